/* rtl/mme_pkg.sv */
// Shared types, constants and a helper function of the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DIM_W      = 4;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = 40;
    localparam int RESULT_W   = 32;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COUNT_W    = ADDR_W + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // One element on its way from the front end to the stores.
    typedef struct packed {
        logic                     is_b;
        logic                     last;
        logic [ADDR_W-1:0]        addr;
        logic signed [ELEM_W-1:0] data;
    } qentry_t;

    // Effective matrix sizes after clamping.
    typedef struct packed {
        logic [DIM_W-1:0] m;
        logic [DIM_W-1:0] n;
        logic [DIM_W-1:0] p;
    } dims_t;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_RUN,
        BK_DRAIN
    } back_state_t;

    // A size of zero acts as one; a size above the store limit acts as the limit.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0) begin
            d = DIM_W'(1);
        end
        else if (r > DIM_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end
        else begin
            d = r;
        end
        return d;
    endfunction

endpackage

/* rtl/mme_queue.sv */
// Two-entry queue that decouples the element front end from the compute back end.
module mme_queue
    import mme_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qentry_t push_data,
    input  logic    pop,
    output qentry_t pop_data,
    output logic    full,
    output logic    empty
);

    qentry_t    slots_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/mme_front.sv */
// Front end: size registers, element acceptance and classification into A or B writes.
module mme_front
    import mme_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [ELEM_W-1:0] element,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [DIM_W-1:0]      wr_data,
    input  logic                  q_full,
    input  logic                  done,
    output logic                  busy,
    output logic                  push,
    output qentry_t               push_data,
    output dims_t                 dims
);

    logic [DIM_W-1:0]   rows_a_reg;
    logic [DIM_W-1:0]   inner_dim_reg;
    logic [DIM_W-1:0]   cols_b_reg;
    logic [COUNT_W-1:0] load_count_reg;
    logic [COUNT_W-1:0] load_count_next;
    logic               loading_second_reg;
    logic               loading_second_next;
    logic               wait_reg;
    logic               accept;
    logic               final_elem;
    logic               cfg_hit;
    logic [COUNT_W-1:0] count_inc;
    logic [2*DIM_W-1:0] size_a;
    logic [2*DIM_W-1:0] size_b;

    assign dims.m = eff_dim(rows_a_reg);
    assign dims.n = eff_dim(inner_dim_reg);
    assign dims.p = eff_dim(cols_b_reg);

    assign busy   = q_full || wait_reg;
    assign accept = start && !busy;
    assign push   = accept;

    assign size_a    = dims.m * dims.n;
    assign size_b    = dims.n * dims.p;
    assign count_inc = load_count_reg + COUNT_W'(1);

    assign cfg_hit = wr_en && ((wr_index == CFG_ROWS_A) || (wr_index == CFG_INNER_DIM) ||
                               (wr_index == CFG_COLS_B));

    always_comb
    begin
        load_count_next     = count_inc;
        loading_second_next = loading_second_reg;
        final_elem          = 1'b0;
        if (!loading_second_reg)
        begin
            if ((2*DIM_W)'(count_inc) >= size_a)
            begin
                load_count_next     = '0;
                loading_second_next = 1'b1;
            end
        end
        else if ((2*DIM_W)'(count_inc) >= size_b)
        begin
            load_count_next     = '0;
            loading_second_next = 1'b0;
            final_elem          = 1'b1;
        end
    end

    assign push_data.is_b = loading_second_reg;
    assign push_data.last = final_elem;
    assign push_data.addr = load_count_reg[ADDR_W-1:0];
    assign push_data.data = element;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg         <= DIM_RESET;
            inner_dim_reg      <= DIM_RESET;
            cols_b_reg         <= DIM_RESET;
            load_count_reg     <= '0;
            loading_second_reg <= 1'b0;
            wait_reg           <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_ROWS_A:    rows_a_reg    <= wr_data;
                    CFG_INNER_DIM: inner_dim_reg <= wr_data;
                    CFG_COLS_B:    cols_b_reg    <= wr_data;
                    default:       ;
                endcase
            end
            // Any write to a real register abandons a partial load.
            if (cfg_hit)
            begin
                load_count_reg     <= '0;
                loading_second_reg <= 1'b0;
            end
            else if (accept)
            begin
                load_count_reg     <= load_count_next;
                loading_second_reg <= loading_second_next;
            end
            if (accept && final_elem)
            begin
                wait_reg <= 1'b1;
            end
            else if (done)
            begin
                wait_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/mme_back.sv */
// Back end: matrix stores, multiply-accumulate pipeline and result registers.
module mme_back
    import mme_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dims_t                   dims,
    input  logic                    q_empty,
    input  qentry_t                 q_data,
    output logic                    pop,
    output logic                    done,
    output logic                    result_valid,
    output logic signed [RESULT_W-1:0] product_value,
    output logic [IDX_W-1:0]        row_index,
    output logic [IDX_W-1:0]        column_index,
    output logic                    last
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'({1'b0, {(RESULT_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];

    back_state_t state_reg;
    back_state_t state_next;

    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [ADDR_W-1:0] a_base_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [ADDR_W-1:0] b_addr_reg;

    logic issue;
    logic init;
    logic last_k;
    logic last_j;
    logic last_i;

    logic signed [ELEM_W-1:0] a_rd_reg;
    logic signed [ELEM_W-1:0] b_rd_reg;
    logic                     s1_valid_reg;
    logic                     s1_first_reg;
    logic                     s1_lastk_reg;
    logic                     s1_final_reg;
    logic [IDX_W-1:0]         s1_row_reg;
    logic [IDX_W-1:0]         s1_col_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     s2_valid_reg;
    logic                     s2_first_reg;
    logic                     s2_lastk_reg;
    logic                     s2_final_reg;
    logic [IDX_W-1:0]         s2_row_reg;
    logic [IDX_W-1:0]         s2_col_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  sat;

    logic                     result_valid_reg;
    logic signed [RESULT_W-1:0] product_value_reg;
    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;
    logic                     last_reg;

    assign last_k = ({1'b0, k_reg} == dims.n - DIM_W'(1));
    assign last_j = ({1'b0, j_reg} == dims.p - DIM_W'(1));
    assign last_i = ({1'b0, i_reg} == dims.m - DIM_W'(1));

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        issue      = 1'b0;
        init       = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            BK_LOAD:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (q_data.last)
                    begin
                        init       = 1'b1;
                        state_next = BK_RUN;
                    end
                end
            end
            BK_RUN:
            begin
                issue = 1'b1;
                if (last_k && last_j && last_i)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !result_valid_reg)
                begin
                    done       = 1'b1;
                    state_next = BK_LOAD;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Stores: written from the queue, read once a cycle with registered data.
    always_ff @(posedge clk)
    begin
        if (pop && !q_data.is_b)
        begin
            a_mem[q_data.addr] <= q_data.data;
        end
        if (pop && q_data.is_b)
        begin
            b_mem[q_data.addr] <= q_data.data;
        end
        a_rd_reg <= a_mem[a_addr_reg];
        b_rd_reg <= b_mem[b_addr_reg];
    end

    // Loop counters and running store addresses: A at i*n+k, B at k*p+j.
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            a_base_reg <= '0;
            a_addr_reg <= '0;
            b_addr_reg <= '0;
        end
        else if (issue)
        begin
            if (!last_k)
            begin
                k_reg      <= k_reg + IDX_W'(1);
                a_addr_reg <= a_addr_reg + ADDR_W'(1);
                b_addr_reg <= b_addr_reg + ADDR_W'(dims.p);
            end
            else if (!last_j)
            begin
                k_reg      <= '0;
                j_reg      <= j_reg + IDX_W'(1);
                a_addr_reg <= a_base_reg;
                b_addr_reg <= ADDR_W'(j_reg) + ADDR_W'(1);
            end
            else
            begin
                k_reg      <= '0;
                j_reg      <= '0;
                i_reg      <= i_reg + IDX_W'(1);
                a_base_reg <= a_base_reg + ADDR_W'(dims.n);
                a_addr_reg <= a_base_reg + ADDR_W'(dims.n);
                b_addr_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            acc_reg          <= '0;
        end
        else
        begin
            s1_valid_reg     <= issue;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg && s2_lastk_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_lastk_reg <= last_k;
        s1_final_reg <= last_j && last_i;
        s1_row_reg   <= i_reg;
        s1_col_reg   <= j_reg;

        prod_reg     <= a_rd_reg * b_rd_reg;
        s2_first_reg <= s1_first_reg;
        s2_lastk_reg <= s1_lastk_reg;
        s2_final_reg <= s1_final_reg;
        s2_row_reg   <= s1_row_reg;
        s2_col_reg   <= s1_col_reg;

        product_value_reg <= sat[RESULT_W-1:0];
        row_reg           <= s2_row_reg;
        col_reg           <= s2_col_reg;
        last_reg          <= s2_final_reg;
    end

    always_comb
    begin
        sum = (s2_first_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        if (sum > SAT_MAX)
        begin
            sat = SAT_MAX;
        end
        else if (sum < SAT_MIN)
        begin
            sat = SAT_MIN;
        end
        else
        begin
            sat = sum;
        end
    end

    assign result_valid  = result_valid_reg;
    assign product_value = product_value_reg;
    assign row_index     = row_reg;
    assign column_index  = col_reg;
    assign last          = last_reg;

endmodule

/* rtl/matrix_multiply_engine_top.sv */
// Top level of the matrix multiply engine: front end, element queue and compute back end.
//
// Channel    Direction  Handshake                 Payload
// ---------  ---------  ------------------------  ------------------------------------------
// element    in         start high, busy low      element (signed Q8.8)
// config     in         wr_en high                wr_index, wr_data
// result     out        result_valid, one cycle   product_value, row_index, column_index, last
//
// Each element transaction is taken while busy is low and goes through a two-entry queue into
// the A or B store. The transaction with the last element of B starts the multiply: one
// multiply-accumulate per cycle, rows_a * inner_dim * cols_b in all (after size clamping).
// busy stays high from that transaction until the final result is out and the back end has
// drained. Reset clears the handshake and sequencing state; the stores need no clearing pass.
// The result receiver cannot stall; each result shows one cycle.
module matrix_multiply_engine_top
    import mme_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [ELEM_W-1:0]   element,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [DIM_W-1:0]           wr_data,
    output logic                       result_valid,
    output logic signed [RESULT_W-1:0] product_value,
    output logic [IDX_W-1:0]           row_index,
    output logic [IDX_W-1:0]           column_index,
    output logic                       last
);

    qentry_t push_data;
    qentry_t pop_data;
    dims_t   dims;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    logic    done;

    // The front end classifies every element as an A or B write and spots the last one.
    mme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .element   (element),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .q_full    (q_full),
        .done      (done),
        .busy      (busy),
        .push      (push),
        .push_data (push_data),
        .dims      (dims)
    );

    // The queue lets the front end take an element while the back end is writing one.
    mme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back end owns the stores and runs the dot products.
    mme_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .dims          (dims),
        .q_empty       (q_empty),
        .q_data        (pop_data),
        .pop           (pop),
        .done          (done),
        .result_valid  (result_valid),
        .product_value (product_value),
        .row_index     (row_index),
        .column_index  (column_index),
        .last          (last)
    );

endmodule

/* rtl/mme_checker.sv */
// Port-level checker for the matrix multiply engine and its bind to the top level.
module mme_checker
    import mme_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic result_valid,
    input logic last
);

    // Results only appear while the engine reports itself busy.
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("result shown while engine is not busy");

    // The final result of a matrix is never followed directly by another result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("result follows the final element of C");

    // When busy drops, the result stream has already ended.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> !result_valid)
        else $error("result shown as busy falls");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .last         (last)
);

/* tb/sv/matrix_multiply_engine_checker.sv */
`timescale 1ns / 100ps
// Checker for the matrix multiply engine: follows the element stream and compares every C element.
module matrix_multiply_engine_checker
    import mme_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic signed [ELEM_W-1:0]   element,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [DIM_W-1:0]           wr_data,
    input  logic                       result_valid,
    input  logic signed [RESULT_W-1:0] product_value,
    input  logic [IDX_W-1:0]           row_index,
    input  logic [IDX_W-1:0]           column_index,
    input  logic                       last,
    output int                         failures,
    output int                         outstanding,
    output int                         results_seen
);

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic                       last;
    } c_elem_t;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -SAT_HI - 1;

    logic [DIM_W-1:0]         rows_cfg;
    logic [DIM_W-1:0]         inner_cfg;
    logic [DIM_W-1:0]         cols_cfg;
    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];
    int                       fill_count;
    bit                       filling_b;
    c_elem_t                  pending_c [$];
    int                       mismatch_count = 0;
    int                       results_total = 0;

    function automatic int clamp_dim(input logic [DIM_W-1:0] r);
        int d;
        d = int'(r);
        if (d == 0) begin
            d = 1;
        end
        else if (d > MAX_DIM) begin
            d = MAX_DIM;
        end
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t ns] MISMATCH: %s", $time, msg);
    endtask

    always @(posedge clk) begin : watch
        int     m;
        int     n;
        int     p;
        int     i;
        int     j;
        int     k;
        longint dot;
        c_elem_t want;
        if (!rst_n) begin
            rows_cfg   = DIM_RESET;
            inner_cfg  = DIM_RESET;
            cols_cfg   = DIM_RESET;
            fill_count = 0;
            filling_b  = 1'b0;
            pending_c.delete();
        end
        else begin
            if (wr_en) begin
                case (wr_index)
                    CFG_ROWS_A:    rows_cfg  = wr_data;
                    CFG_INNER_DIM: inner_cfg = wr_data;
                    CFG_COLS_B:    cols_cfg  = wr_data;
                    default: ;
                endcase
                // A write to a real register abandons any load in progress.
                if (wr_index == CFG_ROWS_A || wr_index == CFG_INNER_DIM ||
                    wr_index == CFG_COLS_B) begin
                    fill_count = 0;
                    filling_b  = 1'b0;
                end
            end

            if (start && !busy) begin
                m = clamp_dim(rows_cfg);
                n = clamp_dim(inner_cfg);
                p = clamp_dim(cols_cfg);
                if (!filling_b) begin
                    a_mem[fill_count % DEPTH] = element;
                    fill_count++;
                    if (fill_count >= m * n) begin
                        fill_count = 0;
                        filling_b  = 1'b1;
                    end
                end
                else begin
                    b_mem[fill_count % DEPTH] = element;
                    fill_count++;
                    if (fill_count >= n * p) begin
                        fill_count = 0;
                        filling_b  = 1'b0;
                        // The sum of at most eight Q8.8 products always fits in 64 bits.
                        for (i = 0; i < m; i++) begin
                            for (j = 0; j < p; j++) begin
                                dot = 0;
                                for (k = 0; k < n; k++) begin
                                    dot += longint'(a_mem[i * n + k]) *
                                           longint'(b_mem[k * p + j]);
                                end
                                if (dot > SAT_HI) begin
                                    dot = SAT_HI;
                                end
                                else if (dot < SAT_LO) begin
                                    dot = SAT_LO;
                                end
                                want.value = RESULT_W'(dot);
                                want.row   = IDX_W'(i);
                                want.col   = IDX_W'(j);
                                want.last  = (i == m - 1) && (j == p - 1);
                                pending_c.push_back(want);
                            end
                        end
                    end
                end
            end

            if (result_valid) begin
                results_total++;
                if (pending_c.size() == 0) begin
                    report_mismatch($sformatf("unexpected result C[%0d][%0d] = %0d",
                        row_index, column_index, product_value));
                end
                else begin
                    want = pending_c.pop_front();
                    if (product_value !== want.value) begin
                        report_mismatch($sformatf("C[%0d][%0d] value %0d, expected %0d",
                            want.row, want.col, product_value, want.value));
                    end
                    if (row_index !== want.row) begin
                        report_mismatch($sformatf("C[%0d][%0d] row index %0d",
                            want.row, want.col, row_index));
                    end
                    if (column_index !== want.col) begin
                        report_mismatch($sformatf("C[%0d][%0d] column index %0d",
                            want.row, want.col, column_index));
                    end
                    if (last !== want.last) begin
                        report_mismatch($sformatf("C[%0d][%0d] last flag %0b, expected %0b",
                            want.row, want.col, last, want.last));
                    end
                end
            end
        end
        outstanding  <= pending_c.size();
        failures     <= mismatch_count;
        results_seen <= results_total;
    end

endmodule

/* tb/sv/matrix_multiply_engine_top_test.sv */
`timescale 1ns / 100ps
// Top of the matrix multiply engine testbench: clock, reset, stimulus and the final verdict.
module matrix_multiply_engine_top_test;
    import mme_pkg::*;

    // The register port is two bits wide, so one index names no register at all.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

    // Number of random element transactions, and how many of the last ones go without gaps.
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL    = 60;

    // Cycles allowed after the last expected result before the block counts as quiet.
    // It leaves room for the pipeline to drain and for the two entries of the element queue.
    localparam int SETTLE_CYCLES = 12;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic signed [ELEM_W-1:0]   element;
    logic                       wr_en;
    logic [CFG_IDX_W-1:0]       wr_index;
    logic [DIM_W-1:0]           wr_data;
    logic                       result_valid;
    logic signed [RESULT_W-1:0] product_value;
    logic [IDX_W-1:0]           row_index;
    logic [IDX_W-1:0]           column_index;
    logic                       last;

    int failures;
    int outstanding;
    int results_seen;

    // Register values as last written, used to know how long each load sequence is.
    logic [DIM_W-1:0] size_reg [3];
    int               items_sent  = 0;
    int               writes_sent = 0;

    matrix_multiply_engine_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .element       (element),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .result_valid  (result_valid),
        .product_value (product_value),
        .row_index     (row_index),
        .column_index  (column_index),
        .last          (last)
    );

    // The checker sees the same pins as the block and predicts every C element on its own.
    matrix_multiply_engine_checker product_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .element       (element),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .result_valid  (result_valid),
        .product_value (product_value),
        .row_index     (row_index),
        .column_index  (column_index),
        .last          (last),
        .failures      (failures),
        .outstanding   (outstanding),
        .results_seen  (results_seen)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // A hung block must not keep the simulator running forever.
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    // Same clamping rule as the block: zero acts as one, anything above the limit as the limit.
    function automatic int eff_size(input logic [DIM_W-1:0] r);
        int d;
        d = int'(r);
        if (d == 0) begin
            d = 1;
        end
        else if (d > MAX_DIM) begin
            d = MAX_DIM;
        end
        return d;
    endfunction

    // Mostly uniform random data, with the edges of the Q8.8 range mixed in often enough
    // that saturated sums show up in the random part as well.
    function automatic logic signed [ELEM_W-1:0] pick_element();
        logic signed [ELEM_W-1:0] v;
        case ($urandom_range(0, 19))
            0:       v = ELEM_MIN;
            1:       v = ELEM_MAX;
            2:       v = '0;
            3:       v = '1;
            default: v = ELEM_W'($urandom);
        endcase
        return v;
    endfunction

    // Every driving task starts at a falling edge and sets start and wr_en exactly once there,
    // so no signal gets two nonblocking assignments in the same time step.

    // One element transaction: start stays high until an edge finds busy low.
    task automatic send_element(input logic signed [ELEM_W-1:0] v);
        @(negedge clk);
        start   <= 1'b1;
        wr_en   <= 1'b0;
        element <= v;
        do begin
            @(posedge clk);
        end while (busy);
        items_sent++;
    endtask

    // One register write; it takes effect at the next rising edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        start    <= 1'b0;
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        if (idx != CFG_UNUSED) begin
            size_reg[idx] = val;
        end
        writes_sent++;
    endtask

    // A gap on the element side of the given number of cycles.
    task automatic idle_burst(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            start <= 1'b0;
            wr_en <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Waits until every expected result has come out and the pipeline has had time to empty.
    // The checker's counters are read at falling edges, well away from their updates.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        wr_en <= 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        int               m;
        int               n;
        int               p;
        int               total;
        int               cut;
        int               r;
        int               pick;
        int               k;
        int               random_items;
        bit               broken;
        logic [DIM_W-1:0] size;

        // Every input has a known value from time zero on.
        rst_n    = 1'b0;
        start    = 1'b0;
        element  = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        size_reg = '{DIM_RESET, DIM_RESET, DIM_RESET};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A few elements of A go in under the reset sizes, and then a
        // register write abandons that load, so the next element must land at A[0][0].
        for (k = 0; k < 3; k++) begin
            send_element(pick_element());
        end
        settle();
        write_reg(CFG_ROWS_A, 4'd0);
        write_reg(CFG_ROWS_A, 4'd2);
        write_reg(CFG_INNER_DIM, 4'd8);
        write_reg(CFG_COLS_B, 4'd1);

        // A 2x8 times 8x1 product at full scale: the first row of A is all most-negative
        // values and the second all most-positive, while B is all most-negative. The two
        // dot products overflow the Q16.16 range, one upward and one downward. Halfway
        // through B a write to the unused index must leave the load running.
        for (k = 0; k < 16; k++) begin
            send_element((k < 8) ? ELEM_MIN : ELEM_MAX);
        end
        for (k = 0; k < 8; k++) begin
            if (k == 4) begin
                settle();
                write_reg(CFG_UNUSED, 4'd5);
            end
            send_element(ELEM_MIN);
        end

        // Out-of-range sizes: fifteen rows clamp to eight, an inner size of zero acts as one.
        settle();
        write_reg(CFG_ROWS_A, 4'd15);
        write_reg(CFG_INNER_DIM, 4'd0);
        write_reg(CFG_COLS_B, 4'd1);
        for (k = 0; k < 9; k++) begin
            send_element(pick_element());
        end

        // The smallest product, 1x1 times 1x1, with both operands at the negative limit.
        settle();
        write_reg(CFG_ROWS_A, 4'd1);
        write_reg(CFG_INNER_DIM, 4'd1);
        send_element(ELEM_MIN);
        send_element(ELEM_MIN);

        // Random part. Each pass is one load sequence of A then B with random data. Most
        // passes first wait for the block to go quiet and write new sizes; the others keep
        // the sizes and offer the next A while the previous C is still being computed, so
        // start waits on busy. About one pass in ten is cut short, and the register write
        // that follows must throw the partial load away.
        random_items = 0;
        broken       = 1'b0;
        while (random_items < RANDOM_ITEMS) begin
            if (broken || $urandom_range(0, 9) >= 3) begin
                settle();
                pick = $urandom_range(0, 2);
                for (r = 0; r < 3; r++) begin
                    if (r == pick || $urandom_range(0, 1) == 1) begin
                        // Sizes stay small most of the time so that many passes fit in
                        // the run; the largest size and the clamped values come up often.
                        k = $urandom_range(0, 19);
                        if (k == 0) begin
                            size = '0;
                        end
                        else if (k == 1) begin
                            size = DIM_W'($urandom_range(MAX_DIM + 1, 15));
                        end
                        else if (k < 4) begin
                            size = DIM_W'(MAX_DIM);
                        end
                        else begin
                            size = DIM_W'($urandom_range(1, 4));
                        end
                        write_reg(CFG_IDX_W'(r), size);
                    end
                end
                if ($urandom_range(0, 9) == 0) begin
                    write_reg(CFG_UNUSED, DIM_W'($urandom));
                end
            end

            m     = eff_size(size_reg[CFG_ROWS_A]);
            n     = eff_size(size_reg[CFG_INNER_DIM]);
            p     = eff_size(size_reg[CFG_COLS_B]);
            total = m * n + n * p;
            broken = (total > 1) && ($urandom_range(0, 9) == 0);
            cut    = broken ? $urandom_range(1, total - 1) : total;

            for (k = 0; k < cut; k++) begin
                if (random_items < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
                    idle_burst($urandom_range(1, 13));
                end
                send_element(pick_element());
                random_items++;
            end
        end

        // Drain: wait for the last C elements, bounded, then give the pipeline time to
        // show anything extra it might still emit.
        @(negedge clk);
        start <= 1'b0;
        wr_en <= 1'b0;
        for (k = 0; k < 4000 && outstanding != 0; k++) begin
            @(negedge clk);
        end
        repeat (4 * SETTLE_CYCLES) @(negedge clk);

        $display("Run covered %0d element transactions and %0d register writes,",
            items_sent, writes_sent);
        $display("with sizes from 1 to %0d and saturation both ways; %0d results checked.",
            MAX_DIM, results_seen);
        if (outstanding != 0) begin
            $display("%0d expected results never came out", outstanding);
        end
        if (failures == 0 && outstanding == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mme_pkg.sv
rtl/mme_queue.sv
rtl/mme_front.sv
rtl/mme_back.sv
rtl/matrix_multiply_engine_top.sv
rtl/mme_checker.sv
tb/sv/matrix_multiply_engine_checker.sv
tb/sv/matrix_multiply_engine_top_test.sv
